// File: rtl/bhpq_pkg.sv
// Shared constants, types and the order compare for the binary heap priority queue.
package bhpq_pkg;

  localparam int CAPACITY  = 16;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OUT_CNT_W = 5;
  localparam int ACT_W     = 2;
  localparam int STS_W     = 2;

  localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK = 2'd2;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

  localparam logic ORDER_MIN = 1'b0;
  localparam logic ORDER_MAX = 1'b1;

  // Sift control handed to every cell.
  typedef struct packed {
    logic active;
    logic up_mode;
    logic down_mode;
  } cell_ctrl_t;

  // Swap a cell decides on this cycle.
  typedef struct packed {
    logic swap_up;
    logic swap_left;
    logic swap_right;
  } cell_dec_t;

  // Swap a neighbor decided that moves a value into this cell.
  typedef struct packed {
    logic from_parent;
    logic from_left;
    logic from_right;
  } cell_recv_t;

  // True when a belongs strictly above b under the selected order.
  function automatic logic ranks_above(input logic [VAL_W-1:0] a,
                                       input logic [VAL_W-1:0] b,
                                       input logic             order);
    logic lt;
    logic gt;
    lt = $signed(a) < $signed(b);
    gt = $signed(a) > $signed(b);
    return (order == ORDER_MAX) ? gt : lt;
  endfunction

endpackage

// File: rtl/bhpq_cell.sv
// One heap entry cell: holds a value and decides swaps with its parent or children.
module bhpq_cell import bhpq_pkg::*; (
  input  logic             clk_i,
  input  logic             order_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic             has_parent_i,
  input  logic [VAL_W-1:0] parent_val_i,
  input  logic [VAL_W-1:0] left_val_i,
  input  logic             left_vld_i,
  input  logic [VAL_W-1:0] right_val_i,
  input  logic             right_vld_i,
  input  cell_recv_t       recv_i,
  input  logic             load_i,
  input  logic [VAL_W-1:0] load_val_i,
  output logic [VAL_W-1:0] val_o,
  output cell_dec_t        dec_o
);

  logic [VAL_W-1:0] val_q, val_d;
  logic [VAL_W-1:0] cand;
  logic             l_win, r_win;

  always_comb begin
    l_win = left_vld_i && ranks_above(left_val_i, val_q, order_i);
    cand  = l_win ? left_val_i : val_q;
    // ties keep the left child
    r_win = right_vld_i && ranks_above(right_val_i, cand, order_i);

    dec_o.swap_up    = ctrl_i.active && ctrl_i.up_mode && has_parent_i &&
                       ranks_above(val_q, parent_val_i, order_i);
    dec_o.swap_right = ctrl_i.active && ctrl_i.down_mode && r_win;
    dec_o.swap_left  = ctrl_i.active && ctrl_i.down_mode && l_win && !r_win;
  end

  always_comb begin
    priority if (load_i) begin
      val_d = load_val_i;
    end else if (dec_o.swap_up || recv_i.from_parent) begin
      val_d = parent_val_i;
    end else if (dec_o.swap_left || recv_i.from_left) begin
      val_d = left_val_i;
    end else if (dec_o.swap_right || recv_i.from_right) begin
      val_d = right_val_i;
    end else begin
      val_d = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// File: rtl/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue: request handshake, sequencer and cell tree.
// A bounded priority queue of signed 32-bit values kept as a binary heap of CAPACITY cells,
// one cell per heap slot, each wired to its parent and its two children. heap_order picks
// min-heap (0) or max-heap (1); changing it does not reorder stored entries. A request is
// taken and its result (top value, status, count, empty flag) is registered into the result slot,
// while the heap repairs itself behind it. A push that lands or a pop that leaves
// entries then walks a single active token one tree level per cycle, a compare and swap at
// each level, and ends on the first cycle with no swap; the next request is taken once that
// walk is over and the result slot is free. A peek, a rejected request, an unused code or a
// pop of the last entry starts no walk; a push or a pop that leaves entries holds the block
// for as long as the depth of its sift walk.
// Entry cells come out of reset undefined; only slots below the fill count are ever read.
module binary_heap_priority_queue import bhpq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write: heap_order
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ACT_W-1:0]     action_i,
  input  logic signed [VAL_W-1:0] push_value_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [VAL_W-1:0] top_value_o,
  output logic [STS_W-1:0]     status_o,
  output logic [OUT_CNT_W-1:0] entry_count_o,
  output logic                 is_empty_o
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UP   = 2'd1;
  localparam logic [1:0] S_DOWN = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CAPACITY-1:0] active_q, active_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic                order_q;

  logic                out_valid_q;
  logic [VAL_W-1:0]    top_q, top_d;
  logic [STS_W-1:0]    sts_q, sts_d;
  logic [OUT_CNT_W-1:0] cnt_q;
  logic                empty_q;

  logic [VAL_W-1:0]    cell_val  [CAPACITY];
  cell_dec_t           cell_dec  [CAPACITY];
  cell_recv_t          cell_recv [CAPACITY];
  logic [CAPACITY-1:0] token_next;
  logic [CAPACITY-1:0] push_load;
  logic                root_load;
  logic [VAL_W-1:0]    last_val;
  logic [IDX_W-1:0]    last_idx;

  logic in_fire, out_fire;
  logic is_full, is_zero;
  logic do_push, do_pop;

  // hold off order writes while a sift is walking the tree
  assign cfg_ready_o = (state_q == S_IDLE);

  // hold the order bit; written only while the block is idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_MIN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      order_q <= cfg_data_i;
    end
  end

  // take a request only when the previous sift is over and the result slot frees up
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  assign is_full  = (fill_q >= CNT_W'(CAPACITY));
  assign is_zero  = (fill_q == '0);
  assign do_push  = in_fire && (action_i == ACT_PUSH) && !is_full;
  assign do_pop   = in_fire && (action_i == ACT_POP) && !is_zero;

  // last stored entry moves to the root on a pop that leaves entries
  assign last_idx = IDX_W'(fill_q - 1'b1);
  assign last_val = cell_val[last_idx];
  assign root_load = do_pop && (fill_q > CNT_W'(1));

  // result fields are all known at accept time
  always_comb begin
    top_d = '0;
    sts_d = STS_OK;
    fill_d = fill_q;
    unique case (action_i)
      ACT_PUSH: begin
        if (is_full) begin
          sts_d = STS_FULL;
        end else begin
          fill_d = fill_q + 1'b1;
        end
      end
      ACT_POP: begin
        if (is_zero) begin
          sts_d = STS_EMPTY;
        end else begin
          top_d  = cell_val[0];
          fill_d = fill_q - 1'b1;
        end
      end
      ACT_PEEK: begin
        if (is_zero) begin
          sts_d = STS_EMPTY;
        end else begin
          top_d = cell_val[0];
        end
      end
      default: begin
        // unused code: report ok and change nothing
        top_d = '0;
      end
    endcase
  end

  // every value the token carries lands in the cell it moves to
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      token_next[k] = cell_recv[k].from_parent | cell_recv[k].from_left |
                      cell_recv[k].from_right;
    end
  end

  // sequencer: start a sift on accept, advance the token, drop back to idle on no swap
  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    unique case (state_q)
      S_IDLE: begin
        if (do_push) begin
          state_d  = S_UP;
          active_d = push_load;
        end else if (root_load) begin
          state_d  = S_DOWN;
          active_d = CAPACITY'(1);
        end
      end
      S_UP, S_DOWN: begin
        active_d = token_next;
        if (token_next == '0) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d  = S_IDLE;
        active_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= '0;
      fill_q   <= '0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      if (in_fire) begin
        fill_q <= fill_d;
      end
    end
  end

  // result register: load on accept, hold until the result transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      top_q   <= top_d;
      sts_q   <= sts_d;
      cnt_q   <= OUT_CNT_W'(fill_d);
      empty_q <= (fill_d == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign top_value_o   = top_q;
  assign status_o      = sts_q;
  assign entry_count_o = cnt_q;
  assign is_empty_o    = empty_q;

  // cell tree: slot i has parent (i-1)/2 and children 2i+1, 2i+2
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int L = 2 * i + 1;
    localparam int R = 2 * i + 2;

    cell_ctrl_t       ctrl;
    logic             has_parent;
    logic [VAL_W-1:0] parent_val;
    logic [VAL_W-1:0] left_val;
    logic             left_vld;
    logic [VAL_W-1:0] right_val;
    logic             right_vld;
    logic             load;
    logic [VAL_W-1:0] load_val;

    assign push_load[i] = do_push && (fill_q == CNT_W'(i));

    assign ctrl.active    = active_q[i];
    assign ctrl.up_mode   = (state_q == S_UP);
    assign ctrl.down_mode = (state_q == S_DOWN);

    if (i == 0) begin : g_root
      assign has_parent               = 1'b0;
      assign parent_val               = '0;
      assign cell_recv[i].from_parent = 1'b0;
      assign load     = push_load[i] || root_load;
      assign load_val = root_load ? last_val : push_value_i;
    end else begin : g_inner
      localparam int P = (i - 1) / 2;
      assign has_parent = 1'b1;
      assign parent_val = cell_val[P];
      if (i % 2 == 1) begin : g_is_left
        assign cell_recv[i].from_parent = cell_dec[P].swap_left;
      end else begin : g_is_right
        assign cell_recv[i].from_parent = cell_dec[P].swap_right;
      end
      assign load     = push_load[i];
      assign load_val = push_value_i;
    end

    if (L < CAPACITY) begin : g_left
      assign left_val               = cell_val[L];
      assign left_vld               = (CNT_W'(L) < fill_q);
      assign cell_recv[i].from_left = cell_dec[L].swap_up;
    end else begin : g_no_left
      assign left_val               = '0;
      assign left_vld               = 1'b0;
      assign cell_recv[i].from_left = 1'b0;
    end

    if (R < CAPACITY) begin : g_right
      assign right_val               = cell_val[R];
      assign right_vld               = (CNT_W'(R) < fill_q);
      assign cell_recv[i].from_right = cell_dec[R].swap_up;
    end else begin : g_no_right
      assign right_val               = '0;
      assign right_vld               = 1'b0;
      assign cell_recv[i].from_right = 1'b0;
    end

    bhpq_cell u_cell (
      .clk_i        (clk_i),
      .order_i      (order_q),
      .ctrl_i       (ctrl),
      .has_parent_i (has_parent),
      .parent_val_i (parent_val),
      .left_val_i   (left_val),
      .left_vld_i   (left_vld),
      .right_val_i  (right_val),
      .right_vld_i  (right_vld),
      .recv_i       (cell_recv[i]),
      .load_i       (load),
      .load_val_i   (load_val),
      .val_o        (cell_val[i]),
      .dec_o        (cell_dec[i])
    );
  end

endmodule

// File: dv/tb_binary_heap_priority_queue.sv
// Self-checking testbench for the binary heap priority queue.
`timescale 1ns / 100ps

module tb_binary_heap_priority_queue;
  import bhpq_pkg::*;

  // The request channel also carries code 3, which the block answers as a no-op.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // Cycles the heap may keep sifting after its last result has gone out.
  localparam int SETTLE_CYCLES = 10;

  // One result transaction as the block reports it.
  typedef struct packed {
    logic signed [VAL_W-1:0] top;
    logic [STS_W-1:0]        status;
    logic [OUT_CNT_W-1:0]    count;
    logic                    is_empty;
  } heap_reply_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic                    cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [ACT_W-1:0]        action_i;
  logic signed [VAL_W-1:0] push_value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [VAL_W-1:0] top_value_o;
  logic [STS_W-1:0]        status_o;
  logic [OUT_CNT_W-1:0]    entry_count_o;
  logic                    is_empty_o;

  binary_heap_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .push_value_i  (push_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .top_value_o   (top_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o)
  );

  // Shadow heap: entries, fill level and the order bit last written.
  logic signed [VAL_W-1:0] heap_mem [CAPACITY];
  logic [OUT_CNT_W-1:0]    heap_fill;
  logic                    heap_max_order;

  // Replies owed by the block, oldest first.
  heap_reply_t pending_replies[$];

  // Percent of cycles the sender sits idle / the receiver holds off.
  int in_idle_pct;
  int out_stall_pct;

  int mismatch_count;
  int requests_sent;
  int replies_checked;
  int full_rejects;
  int empty_rejects;
  int deepest_fill;

  // 10 ns clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow heap
  // ---------------------------------------------------------------------------

  // True when a must sit strictly above b under the current order.
  function automatic bit outranks(input logic signed [VAL_W-1:0] a,
                                  input logic signed [VAL_W-1:0] b);
    return heap_max_order ? (a > b) : (a < b);
  endfunction

  function automatic void swap_entries(input int i, input int j);
    logic signed [VAL_W-1:0] held;
    held        = heap_mem[i];
    heap_mem[i] = heap_mem[j];
    heap_mem[j] = held;
  endfunction

  // Apply one accepted request to the shadow heap and return the reply it owes.
  function automatic heap_reply_t apply_request(input logic [ACT_W-1:0]        act,
                                                input logic signed [VAL_W-1:0] val);
    heap_reply_t reply;
    int          pos;
    int          parent;
    int          left;
    int          right;
    int          best;
    bit          settled;
    reply.top    = '0;
    reply.status = STS_OK;
    case (act)
      ACT_PUSH: begin
        if (heap_fill >= CAPACITY) begin
          reply.status = STS_FULL;
          full_rejects++;
        end else begin
          // Append at the tail and bubble toward the root while strictly better.
          heap_mem[heap_fill] = val;
          pos     = heap_fill;
          settled = 1'b0;
          while (pos > 0 && !settled) begin
            parent = (pos - 1) / 2;
            if (outranks(heap_mem[pos], heap_mem[parent])) begin
              swap_entries(pos, parent);
              pos = parent;
            end else begin
              settled = 1'b1;
            end
          end
          heap_fill++;
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (heap_fill == 0) begin
          reply.status = STS_EMPTY;
          empty_rejects++;
        end else begin
          reply.top = heap_mem[0];
          if (act == ACT_POP) begin
            heap_fill--;
            if (heap_fill > 0) begin
              // Move the tail to the root and push it down toward the better child;
              // on a tie between children the left one wins.
              heap_mem[0] = heap_mem[heap_fill];
              pos     = 0;
              settled = 1'b0;
              while (!settled) begin
                left  = 2 * pos + 1;
                right = left + 1;
                best  = pos;
                if (left < heap_fill && outranks(heap_mem[left], heap_mem[best]))
                  best = left;
                if (right < heap_fill && outranks(heap_mem[right], heap_mem[best]))
                  best = right;
                if (best == pos) begin
                  settled = 1'b1;
                end else begin
                  swap_entries(pos, best);
                  pos = best;
                end
              end
            end
          end
        end
      end
      default: ;  // unused code: no change, plain ok reply
    endcase
    reply.count    = heap_fill;
    reply.is_empty = (heap_fill == 0);
    if (heap_fill > deepest_fill) deepest_fill = heap_fill;
    return reply;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    // Keep the log readable when the block is badly off; the count stays exact.
    if (mismatch_count < 100) $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  // Send one request transaction; hold it until taken, then predict its reply.
  task automatic send_request(input logic [ACT_W-1:0]        act,
                              input logic signed [VAL_W-1:0] val);
    @(negedge clk_i);
    // Idle cycles carry random junk on the payload with valid low.
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i   = 1'b0;
      action_i     = ACT_W'($urandom);
      push_value_i = $urandom;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    action_i     = act;
    push_value_i = val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_replies.push_back(apply_request(act, val));
    requests_sent++;
  endtask

  // Drop the request line, wait out every owed reply and let the heap settle.
  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the order bit while the block is quiet; stored entries stay where they are.
  task automatic write_heap_order(input logic order);
    wait_quiet();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = order;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    heap_max_order = order;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Compare every result transaction against the oldest owed reply.
  always @(posedge clk_i) begin : reply_check
    heap_reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result with no request outstanding (top %0d status %0d)",
                                  top_value_o, status_o));
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (top_value_o !== want.top)
          report_mismatch($sformatf("top_value got %0d want %0d", top_value_o, want.top));
        if (status_o !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
        if (entry_count_o !== want.count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    entry_count_o, want.count));
        if (is_empty_o !== want.is_empty)
          report_mismatch($sformatf("is_empty got %0b want %0b", is_empty_o, want.is_empty));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Often short values so ties are frequent, some extremes, the rest full range.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       begin
        case ($urandom_range(0, 3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          default: return -1;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Pop, peek and the unused code on an empty heap.
  task automatic test_empty_rejects();
    send_request(ACT_POP, pick_value());
    send_request(ACT_PEEK, pick_value());
    send_request(ACT_UNUSED, pick_value());
  endtask

  // Fill to capacity with extremes and ties, then bounce off the full heap.
  task automatic test_fill_and_full();
    logic signed [VAL_W-1:0] fill_vals [CAPACITY];
    fill_vals = '{VAL_MAX, VAL_MIN, 0, -1, 1, 5, 5, 5,
                  -7, 100, -100, 32'sh4000_0000, 32'shC000_0000, 3, 5, -1};
    foreach (fill_vals[i]) send_request(ACT_PUSH, fill_vals[i]);
    send_request(ACT_PUSH, 0);
    send_request(ACT_PEEK, pick_value());
    send_request(ACT_UNUSED, pick_value());
  endtask

  // Take a few entries off the top, leaving the rest for the order change.
  task automatic test_partial_drain();
    repeat (3) send_request(ACT_POP, pick_value());
  endtask

  // Random traffic that swings between filling and draining so both ends are hit often.
  task automatic test_random_traffic(input logic order, input int idle_pct,
                                     input int stall_pct, input int n_items);
    logic [ACT_W-1:0] act;
    int               roll;
    bit               filling;
    write_heap_order(order);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    filling       = (heap_fill < CAPACITY / 2);
    repeat (n_items) begin
      if (heap_fill == CAPACITY && $urandom_range(0, 1)) filling = 1'b0;
      if (heap_fill == 0 && $urandom_range(0, 1)) filling = 1'b1;
      if ($urandom_range(0, 24) == 0) filling = !filling;
      roll = $urandom_range(0, 99);
      if (roll < 3)                              act = ACT_UNUSED;
      else if (roll < 13)                        act = ACT_PEEK;
      else if (roll < (filling ? 78 : 35))       act = ACT_PUSH;
      else                                       act = ACT_POP;
      send_request(act, pick_value());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = 1'b0;
    in_valid_i     = 1'b0;
    action_i       = ACT_PUSH;
    push_value_i   = '0;
    out_ready_i    = 1'b1;
    heap_fill      = '0;
    heap_max_order = ORDER_MIN;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    mismatch_count  = 0;
    requests_sent   = 0;
    replies_checked = 0;
    full_rejects    = 0;
    empty_rejects   = 0;
    deepest_fill    = 0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, min order, no idling.
    write_heap_order(ORDER_MIN);
    test_empty_rejects();
    test_fill_and_full();
    test_partial_drain();

    // Random part: flip the order with entries still stored, one idle mix per phase.
    test_random_traffic(ORDER_MAX, 0, 0, 110);
    test_random_traffic(ORDER_MIN, 47, 0, 110);
    test_random_traffic(ORDER_MAX, 0, 47, 110);
    test_random_traffic(ORDER_MIN, 24, 24, 120);

    wait_quiet();
    $display("Covered %0d requests over both heap orders and four idle/stall mixes;",
             requests_sent);
    $display("%0d results checked, %0d full rejects, %0d empty rejects, peak fill %0d.",
             replies_checked, full_rejects, empty_rejects, deepest_fill);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("Timeout waiting for the block");
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
rtl/bhpq_pkg.sv
rtl/bhpq_cell.sv
rtl/binary_heap_priority_queue.sv
dv/tb_binary_heap_priority_queue.sv
